// ===== hdl/aumt_pkg.sv =====
// Package for the motor packet audio transmitter: payload structs, config
// register map and shared constants. No dependencies.
`default_nettype none
package aumt_pkg;

  localparam int unsigned PacketBytes = 4;
  localparam int unsigned DataBits    = 8;
  localparam int unsigned ByteIdxW    = $clog2(PacketBytes);
  localparam int unsigned BitIdxW     = 5;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLES_PER_BIT = 2'd0,
    REG_STOP_BIT_COUNT  = 2'd1,
    REG_AMPLITUDE       = 2'd2,
    REG_SYNC_BYTE       = 2'd3
  } cfg_reg_t;

  localparam logic [7:0]  SpbReset   = 8'd2;
  localparam logic [3:0]  StopsReset = 4'd10;
  localparam logic [14:0] AmpReset   = 15'd32767;
  localparam logic [7:0]  SyncReset  = 8'hBE;

  typedef struct packed {
    logic        cmd_valid;
    logic signed [7:0] motor_left;
    logic signed [7:0] motor_right;
  } in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               busy_res;
    logic               packet_done;
  } out_t;

  typedef struct packed {
    logic [7:0]  samples_per_bit;
    logic [3:0]  stop_bit_count;
    logic [14:0] amplitude;
    logic [7:0]  sync_byte;
  } cfg_t;

  // Magnitude of a two's complement speed; -128 comes out as 0x80.
  function automatic logic [7:0] magnitude8(input logic [7:0] v);
    logic [7:0] r;
    r = v[7] ? 8'(~v + 8'd1) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/audio_uart_motor_packet_tx.sv =====
// Top level of the motor packet audio transmitter: packet sequencer and
// output register. Depends on aumt_pkg and aumt_cfg.
//
//   port group   direction  payload  handshake
//   in_*         request in in_t     in_valid / in_stall
//   out_*        result out out_t    out_valid / out_stall
//   cfg_*        write in   15 bits  cfg_we, cfg_index
//
// One request per cycle unless in_stall is high, one result per request, passed
// through the output register. The sequencer counters and the result are
// computed in a single combinational pass from the current state.
// in_stall follows out_stall only while the output register is full.
// Reset (rst, synchronous) clears the sequencer and restores config
// defaults; the packet byte store needs no reset.
`default_nettype none
module audio_uart_motor_packet_tx
  import aumt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_t                 in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_t                     out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cfg_t cfg;

  aumt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic                sending, sending_next;
  logic                pending_valid, pending_valid_next;
  logic [7:0]          pending_left, pending_left_next;
  logic [7:0]          pending_right, pending_right_next;
  logic [7:0]          packet_bytes [PacketBytes];
  logic [ByteIdxW-1:0] byte_index, byte_index_next;
  logic [BitIdxW-1:0]  bit_index, bit_index_next;
  logic [7:0]          sample_count, sample_count_next;
  logic                start;
  out_t                result;

  logic                accept;
  logic [7:0]          spb;
  logic [3:0]          stops;
  logic [BitIdxW-1:0]  bits_per_byte;
  logic [15:0]         pos, neg;
  logic [7:0]          cur;
  logic [BitIdxW-1:0]  bit_cur, bit_inc;
  logic [ByteIdxW-1:0] byte_cur;
  logic [7:0]          count_inc;
  logic                high;
  logic                done;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    spb           = (cfg.samples_per_bit == 8'd0) ? 8'd1 : cfg.samples_per_bit;
    stops         = (cfg.stop_bit_count == 4'd0) ? 4'd1 : cfg.stop_bit_count;
    bits_per_byte = BitIdxW'(1 + DataBits) + BitIdxW'(stops);
    pos           = {1'b0, cfg.amplitude};
    neg           = 16'(~pos + 16'd1);

    pending_left_next  = pending_left;
    pending_right_next = pending_right;
    pending_valid_next = pending_valid;
    if (in_data.cmd_valid) begin
      pending_left_next  = in_data.motor_left;
      pending_right_next = in_data.motor_right;
      pending_valid_next = 1'b1;
    end

    // Start a packet on any idle tick with a command waiting.
    start = !sending && pending_valid_next;
    if (start) begin
      pending_valid_next = 1'b0;
    end
    byte_cur = start ? '0 : byte_index;
    bit_cur  = start ? '0 : bit_index;

    cur = packet_bytes[byte_cur];
    if (bit_cur == '0) begin
      high = 1'b0;
    end else if (bit_cur <= BitIdxW'(DataBits)) begin
      high = cur[3'(bit_cur - BitIdxW'(1))];
    end else begin
      high = 1'b1;
    end

    sending_next      = sending || start;
    byte_index_next   = byte_cur;
    bit_index_next    = bit_cur;
    count_inc         = (start ? 8'd0 : sample_count) + 8'd1;
    sample_count_next = count_inc;
    bit_inc           = bit_cur + BitIdxW'(1);
    done              = 1'b0;
    if (sending_next) begin
      // Advance to the next bit once the count reaches the bit length.
      if (count_inc >= spb || count_inc == 8'd0) begin
        sample_count_next = 8'd0;
        bit_index_next    = bit_inc;
        if (bit_inc >= bits_per_byte) begin
          bit_index_next = '0;
          if (byte_cur == ByteIdxW'(PacketBytes - 1)) begin
            byte_index_next = '0;
            sending_next    = 1'b0;
            done            = 1'b1;
          end else begin
            byte_index_next = byte_cur + ByteIdxW'(1);
          end
        end
      end
    end else begin
      sample_count_next = sample_count;
    end

    result.sample      = (sending || start) ? (high ? pos : neg) : pos;
    result.busy_res    = sending || start;
    result.packet_done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending       <= 1'b0;
      pending_valid <= 1'b0;
      pending_left  <= '0;
      pending_right <= '0;
      byte_index    <= '0;
      bit_index     <= '0;
      sample_count  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        sending       <= sending_next;
        pending_valid <= pending_valid_next;
        pending_left  <= pending_left_next;
        pending_right <= pending_right_next;
        byte_index    <= byte_index_next;
        bit_index     <= bit_index_next;
        sample_count  <= sample_count_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
      if (start) begin
        packet_bytes[0] <= cfg.sync_byte;
        packet_bytes[1] <= {6'd0, pending_right_next[7], pending_left_next[7]};
        packet_bytes[2] <= magnitude8(pending_left_next);
        packet_bytes[3] <= magnitude8(pending_right_next);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/aumt_cfg.sv =====
// Configuration register bank for the motor packet audio transmitter.
// Depends on aumt_pkg for the register map and reset values.
`default_nettype none
module aumt_cfg
  import aumt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_bit <= SpbReset;
      cfg.stop_bit_count  <= StopsReset;
      cfg.amplitude       <= AmpReset;
      cfg.sync_byte       <= SyncReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLES_PER_BIT: cfg.samples_per_bit <= cfg_data[7:0];
        REG_STOP_BIT_COUNT:  cfg.stop_bit_count  <= cfg_data[3:0];
        REG_AMPLITUDE:       cfg.amplitude       <= cfg_data[14:0];
        REG_SYNC_BYTE:       cfg.sync_byte       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/audio_uart_motor_packet_tx_tb.sv =====
// Testbench for audio_uart_motor_packet_tx: random and directed motor commands
// with a cycle-accurate sample predictor. Depends on aumt_pkg and the block RTL.
`timescale 1ns / 100ps
module audio_uart_motor_packet_tx_tb;
  import aumt_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_we = 1'b0;
  cfg_reg_t            cfg_index = REG_SAMPLES_PER_BIT;
  logic [CfgDataW-1:0] cfg_data = '0;

  audio_uart_motor_packet_tx uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  in_t  req_q[$];
  out_t sample_q[$];
  int   mismatches = 0;
  int   tx_idle_pm = 0;
  int   rx_idle_pm = 0;
  int   tx_wait = 0;
  int   stall_left = 0;
  logic rx_hold = 1'b0;
  logic hold_go = 1'b0;

  // Shadow registers and transmitter state
  logic [7:0]  spb_reg;
  logic [3:0]  stops_reg;
  logic [14:0] amp_reg;
  logic [7:0]  sync_reg;
  logic        line_busy;
  logic        cmd_pending;
  logic [7:0]  cmd_left;
  logic [7:0]  cmd_right;
  logic [7:0]  frame_byte[PacketBytes];
  int unsigned byte_pos;
  int unsigned bit_pos;
  int unsigned tick_count;

  initial begin
    forever #1 clk = ~clk;
  end

  // Sample produced by one tick; advances the transmitter state.
  function automatic out_t next_sample(input in_t req);
    out_t        res;
    int unsigned spb;
    int unsigned bpb;
    logic [15:0] hi_lvl;
    logic [7:0]  cur;
    logic        lvl;
    spb = (spb_reg == 8'd0) ? 1 : spb_reg;
    bpb = 1 + DataBits + ((stops_reg == 4'd0) ? 1 : stops_reg);
    hi_lvl = {1'b0, amp_reg};
    if (req.cmd_valid) begin
      cmd_left = req.motor_left;
      cmd_right = req.motor_right;
      cmd_pending = 1'b1;
    end
    // A pending command starts on any idle tick, this one included
    if (!line_busy && cmd_pending) begin
      frame_byte[0] = sync_reg;
      frame_byte[1] = {6'd0, cmd_right[7], cmd_left[7]};
      frame_byte[2] = cmd_left[7] ? 8'd0 - cmd_left : cmd_left;
      frame_byte[3] = cmd_right[7] ? 8'd0 - cmd_right : cmd_right;
      cmd_pending = 1'b0;
      line_busy = 1'b1;
      byte_pos = 0;
      bit_pos = 0;
      tick_count = 0;
    end
    res.sample = hi_lvl;
    res.busy_res = line_busy;
    res.packet_done = 1'b0;
    if (line_busy) begin
      cur = frame_byte[byte_pos];
      if (bit_pos == 0) lvl = 1'b0;
      else if (bit_pos <= DataBits) lvl = cur[bit_pos - 1];
      else lvl = 1'b1;
      tick_count = (tick_count + 1) % 256;
      // Counters past a freshly lowered limit advance at once
      if (tick_count >= spb || tick_count == 0) begin
        tick_count = 0;
        bit_pos++;
        if (bit_pos >= bpb) begin
          bit_pos = 0;
          if (byte_pos + 1 >= PacketBytes) begin
            byte_pos = 0;
            line_busy = 1'b0;
            res.packet_done = 1'b1;
          end else begin
            byte_pos++;
          end
        end
      end
      res.sample = lvl ? hi_lvl : 16'd0 - hi_lvl;
    end
    return res;
  endfunction

  function automatic int pause_len(input int pm);
    if ($urandom_range(999) >= pm) return 0;
    if ($urandom_range(9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_t rand_req(input logic with_cmd);
    in_t r;
    r.cmd_valid = with_cmd;
    r.motor_left = 8'($urandom);
    r.motor_right = 8'($urandom);
    return r;
  endfunction

  function automatic in_t cmd_req(input logic [7:0] left, input logic [7:0] right);
    in_t r;
    r.cmd_valid = 1'b1;
    r.motor_left = left;
    r.motor_right = right;
    return r;
  endfunction

  function automatic int frame_ticks();
    int spb;
    int stops;
    spb = (spb_reg == 8'd0) ? 1 : spb_reg;
    stops = (stops_reg == 4'd0) ? 1 : stops_reg;
    return PacketBytes * (1 + DataBits + stops) * spb;
  endfunction

  // Request driver and predictor
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
      spb_reg = SpbReset;
      stops_reg = StopsReset;
      amp_reg = AmpReset;
      sync_reg = SyncReset;
      line_busy = 1'b0;
      cmd_pending = 1'b0;
      cmd_left = '0;
      cmd_right = '0;
      byte_pos = 0;
      bit_pos = 0;
      tick_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SAMPLES_PER_BIT: spb_reg = cfg_data[7:0];
          REG_STOP_BIT_COUNT:  stops_reg = cfg_data[3:0];
          REG_AMPLITUDE:       amp_reg = cfg_data[14:0];
          REG_SYNC_BYTE:       sync_reg = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) sample_q.push_back(next_sample(in_data));
      // Hold the request while stalled
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          in_data <= req_q.pop_front();
          in_valid <= 1'b1;
          tx_wait <= pause_len(tx_idle_pm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : rx_side
    out_t want;
    int   pause;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          $error("unexpected result: sample %0d busy_res %0b packet_done %0b",
                 out_data.sample, out_data.busy_res, out_data.packet_done);
          mismatches++;
        end else begin
          want = sample_q.pop_front();
          if (out_data.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, out_data.sample);
            mismatches++;
          end
          if (out_data.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, out_data.busy_res);
            mismatches++;
          end
          if (out_data.packet_done !== want.packet_done) begin
            $error("packet_done: expected %0b, got %0b", want.packet_done,
                   out_data.packet_done);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        pause = pause_len(rx_idle_pm);
        stall_left <= (pause > 0) ? pause - 1 : 0;
        out_stall <= rx_hold || (pause > 0);
      end
    end
  end

  // Long receiver hold so the output register fills and backs up the input
  initial begin
    wait (hold_go);
    repeat (20) @(negedge clk);
    rx_hold = 1'b1;
    repeat (300) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic drain();
    while (req_q.size() != 0 || in_valid || sample_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] spb, input logic [3:0] stops,
                          input logic [14:0] amp, input logic [7:0] sync);
    drain();
    write_reg(REG_SAMPLES_PER_BIT, CfgDataW'(spb));
    write_reg(REG_STOP_BIT_COUNT, CfgDataW'(stops));
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_SYNC_BYTE, CfgDataW'(sync));
    @(negedge clk);
  endtask

  task automatic queue_quiet(input int n);
    repeat (n) req_q.push_back(rand_req(1'b0));
  endtask

  // Mostly whole packets with random content, some early commands, some noise
  task automatic queue_random(input int n);
    int made;
    int plen;
    int quiet;
    int r;
    int k;
    made = 0;
    plen = frame_ticks();
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 70) quiet = plen + int'($urandom_range(8)) - 4;
      else if (r < 85) quiet = $urandom_range(plen);
      else quiet = $urandom_range(6);
      req_q.push_back(rand_req(1'b1));
      made++;
      for (k = 0; k < quiet && made < n; k++) begin
        req_q.push_back(rand_req(r >= 85 && $urandom_range(4) == 0));
        made++;
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] spb, input logic [3:0] stops,
                           input logic [14:0] amp, input logic [7:0] sync,
                           input int n, input int tx_pm, input int rx_pm);
    set_regs(spb, stops, amp, sync);
    tx_idle_pm = tx_pm;
    rx_idle_pm = rx_pm;
    queue_random(n);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: speed extremes, sign combinations, commands while sending
    set_regs(8'd1, 4'd1, 15'd32767, 8'hBE);
    tx_idle_pm = 100;
    rx_idle_pm = 100;
    req_q.push_back(cmd_req(8'sd0, 8'sd0));
    queue_quiet(44);
    req_q.push_back(cmd_req(8'sd127, 8'sd127));
    queue_quiet(44);
    req_q.push_back(cmd_req(-8'sd128, -8'sd128));
    queue_quiet(44);
    req_q.push_back(cmd_req(-8'sd1, 8'sd1));
    queue_quiet(44);
    req_q.push_back(cmd_req(-8'sd128, 8'sd127));
    queue_quiet(44);
    req_q.push_back(cmd_req(8'sd10, -8'sd10));
    queue_quiet(5);
    req_q.push_back(cmd_req(8'sd20, -8'sd20));
    queue_quiet(3);
    // replaces the pending command before it is sent
    req_q.push_back(cmd_req(-8'sd100, 8'sd100));
    queue_quiet(90);

    run_phase(SpbReset, StopsReset, AmpReset, SyncReset, 200, 150, 150);
    run_phase(8'd0, 4'd0, 15'd0, 8'h00, 200, 50, 50);
    run_phase(8'd1, 4'd15, 15'd1, 8'hFF, 200, 0, 0);
    run_phase(8'd3, 4'd2, 15'($urandom), 8'($urandom), 200, 200, 100);
    // Slow line left mid packet; the next write shrinks its limits
    run_phase(8'd255, 4'd15, 15'd32767, 8'h55, 150, 100, 100);
    run_phase(8'd1, 4'd1, 15'd12345, 8'hA5, 200, 0, 30);
    hold_go = 1'b1;
    run_phase(8'd4, 4'd3, 15'($urandom), 8'($urandom), 200, 300, 300);

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== audio_uart_motor_packet_tx.f =====
hdl/aumt_pkg.sv
hdl/aumt_cfg.sv
hdl/audio_uart_motor_packet_tx.sv
sim/audio_uart_motor_packet_tx_tb.sv
